>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pcu_pkg.sv
// ----------------------------------------------------------------------------
// Polygon containment package
// Operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package pcu_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_DELETE  = 3'd1,
        OP_TEST    = 3'd2,
        OP_COMPARE = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP,
        ST_T_PREV,
        ST_T_EDGE,
        ST_T_MUL,
        ST_T_DLD,
        ST_T_DIV,
        ST_T_SUM,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/pcu_in_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one polygon operation and its point.
// ----------------------------------------------------------------------------
interface pcu_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   op;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output op, output point_x, output point_y, input ready);
    modport sink   (input valid, input op, input point_x, input point_y, output ready);
endinterface

>>> rtl/core/pcu_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface pcu_out_if #(
    parameter int CNT_BITS = 9
);
    logic                valid;
    logic                ready;
    logic                inside_res;
    logic                same_as_last;
    logic [CNT_BITS-1:0] vertex_count;
    logic [1:0]          status;

    modport source (output valid, output inside_res, output same_as_last,
                    output vertex_count, output status, input ready);
    modport sink   (input valid, input inside_res, input same_as_last,
                    input vertex_count, input status, output ready);
endinterface

>>> rtl/core/pcu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/core/polygon_point_containment_unit.sv
// ----------------------------------------------------------------------------
// Polygon point containment unit
// Vertex store with running bounding box and crossing-number point test.
// ----------------------------------------------------------------------------
// One command is taken at a time; the command port drops ready from the transfer until
// the result is in the output register. Add, delete, clear, compare on an empty store and
// an empty or box-rejected test go straight to the done state; compare otherwise passes
// through the compare state first. A point test that passes the strict box check walks
// the store, which has one read port, one vertex per cycle while no candidate edge is
// being multiplied or divided; each candidate edge goes through one multiplier and a
// shared radix-2 restoring divider that yields one quotient bit per cycle. A finished
// result waits in the output register while the next command is already taken. The
// vertex store needs no clearing pass after reset.
module polygon_point_containment_unit #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcu_in_if.sink    i_cmd,
    pcu_out_if.source o_res
);
    import pcu_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = CW + 3;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int SW = $clog2(DW + 1);

    t_state r_state, n_state;

    logic [NW-1:0]        r_count;
    logic signed [CW-1:0] r_box_min_x, r_box_max_x, r_box_min_y, r_box_max_y;
    logic signed [CW-1:0] r_px, r_py;
    logic signed [CW-1:0] r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic [AW-1:0]        r_idx;
    logic                 r_inside, r_same;
    t_status              r_status;
    logic signed [DW-1:0] r_dy, r_dx, r_den;
    logic signed [PW-1:0] r_prod;
    logic [DW-1:0]        r_rem, r_quo, r_dmag;
    logic                 r_qneg;
    logic [SW-1:0]        r_step;

    logic            r_o_valid, r_o_inside, r_o_same;
    logic [NW-1:0]   r_o_count;
    t_status         r_o_status;

    logic                 w_acc, w_full, w_empty, w_box_pass;
    t_op                  w_op;
    logic [NW-1:0]        w_cnt_m1;
    logic [AW-1:0]        w_last, w_idx_nx;
    logic [2*CW-1:0]      w_rd_data;
    logic signed [CW-1:0] w_rd_x, w_rd_y;
    logic                 w_straddle, w_left, w_cand, w_at_end;
    logic signed [PW-1:0] w_prod;
    logic [PW-1:0]        w_pmag;
    logic [DW-1:0]        w_dmag;
    logic [DW:0]          w_trial, w_diff;
    logic                 w_ge, w_div_last;
    logic [XW-1:0]        w_qabs;
    logic signed [XW-1:0] w_qs, w_xcut;
    logic                 w_hit;
    logic                 w_in_ready, w_rd_en, w_out_load, w_wr_en;
    logic [AW-1:0]        w_rd_addr;

    pcu_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data ({i_cmd.point_x, i_cmd.point_y}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_acc      = i_cmd.valid && w_in_ready;
    assign w_op       = t_op'(i_cmd.op);
    assign w_full     = (r_count == NW'(MAX_VERTICES));
    assign w_empty    = (r_count == '0);
    assign w_cnt_m1   = r_count - NW'(1);
    assign w_last     = w_cnt_m1[AW-1:0];
    assign w_idx_nx   = r_idx + AW'(1);
    assign w_wr_en    = w_acc && (w_op == OP_ADD) && !w_full;
    assign w_box_pass = (r_box_min_x < i_cmd.point_x) && (r_box_max_x > i_cmd.point_x) &&
                        (r_box_min_y < i_cmd.point_y) && (r_box_max_y > i_cmd.point_y);

    assign w_rd_x = w_rd_data[2*CW-1:CW];
    assign w_rd_y = w_rd_data[CW-1:0];

    // edge between previous vertex (j) and current read vertex (i)
    assign w_straddle = ((w_rd_y < r_py) && (r_prev_y >= r_py)) ||
                        ((r_prev_y < r_py) && (w_rd_y >= r_py));
    assign w_left     = (w_rd_x <= r_px) || (r_prev_x <= r_px);
    assign w_cand     = w_straddle && w_left;
    assign w_at_end   = (r_idx == w_last);

    assign w_prod = r_dy * r_dx;
    assign w_pmag = r_prod[PW-1] ? -r_prod : r_prod;
    assign w_dmag = r_den[DW-1] ? -r_den : r_den;

    assign w_trial    = {r_rem, r_quo[DW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_dmag});
    assign w_diff     = w_trial - {1'b0, r_dmag};
    assign w_div_last = (r_step == SW'(DW - 1));

    assign w_qabs = {{(XW - DW){1'b0}}, r_quo};
    assign w_qs   = r_qneg ? -w_qabs : w_qabs;
    assign w_xcut = XW'(r_cur_x) + w_qs;
    assign w_hit  = (w_xcut < XW'(r_px));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_DONE;
                    if (w_op == OP_TEST && w_box_pass && !w_empty) begin
                        n_state = ST_T_PREV;
                    end else if (w_op == OP_COMPARE && !w_empty) begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP:    n_state = ST_DONE;
            ST_T_PREV: n_state = ST_T_EDGE;
            ST_T_EDGE: begin
                if (w_cand) begin
                    n_state = ST_T_MUL;
                end else if (w_at_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_T_MUL:  n_state = ST_T_DLD;
            ST_T_DLD:  n_state = ST_T_DIV;
            ST_T_DIV: begin
                if (w_div_last) begin
                    n_state = ST_T_SUM;
                end
            end
            ST_T_SUM:  n_state = w_at_end ? ST_DONE : ST_T_EDGE;
            ST_DONE: begin
                if (!r_o_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                w_rd_en    = 1'b1;
                w_rd_addr  = w_last;
            end
            ST_T_PREV: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx;
            end
            ST_T_EDGE: begin
                w_rd_en   = !w_cand && !w_at_end;
                w_rd_addr = w_idx_nx;
            end
            ST_T_SUM: begin
                w_rd_en   = !w_at_end;
                w_rd_addr = w_idx_nx;
            end
            ST_DONE: begin
                w_out_load = !r_o_valid || o_res.ready;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_box_min_x <= '0;
            r_box_max_x <= '0;
            r_box_min_y <= '0;
            r_box_max_y <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_px     <= i_cmd.point_x;
                        r_py     <= i_cmd.point_y;
                        r_inside <= 1'b0;
                        r_same   <= 1'b0;
                        r_idx    <= '0;
                        unique case (w_op)
                            OP_ADD: begin
                                r_status <= w_full ? STAT_FULL : STAT_OK;
                                if (!w_full) begin
                                    r_count <= r_count + NW'(1);
                                    if (w_empty) begin
                                        r_box_min_x <= i_cmd.point_x;
                                        r_box_max_x <= i_cmd.point_x;
                                        r_box_min_y <= i_cmd.point_y;
                                        r_box_max_y <= i_cmd.point_y;
                                    end else begin
                                        if (i_cmd.point_x > r_box_max_x) begin
                                            r_box_max_x <= i_cmd.point_x;
                                        end else if (r_box_min_x > i_cmd.point_x) begin
                                            r_box_min_x <= i_cmd.point_x;
                                        end
                                        if (i_cmd.point_y > r_box_max_y) begin
                                            r_box_max_y <= i_cmd.point_y;
                                        end else if (r_box_min_y > i_cmd.point_y) begin
                                            r_box_min_y <= i_cmd.point_y;
                                        end
                                    end
                                end
                            end
                            OP_DELETE: begin
                                r_status <= STAT_OK;
                                if (!w_empty) begin
                                    r_count <= w_cnt_m1;
                                end
                            end
                            OP_COMPARE: begin
                                r_status <= w_empty ? STAT_EMPTY : STAT_OK;
                            end
                            OP_CLEAR: begin
                                r_status <= STAT_OK;
                                r_count  <= '0;
                            end
                            default: begin
                                r_status <= STAT_OK;
                            end
                        endcase
                    end
                end
                ST_CMP: begin
                    r_same <= (w_rd_x == r_px) && (w_rd_y == r_py);
                end
                ST_T_PREV: begin
                    r_prev_x <= w_rd_x;
                    r_prev_y <= w_rd_y;
                end
                ST_T_EDGE: begin
                    r_cur_x <= w_rd_x;
                    r_cur_y <= w_rd_y;
                    r_dy    <= DW'(r_py) - DW'(w_rd_y);
                    r_dx    <= DW'(r_prev_x) - DW'(w_rd_x);
                    r_den   <= DW'(r_prev_y) - DW'(w_rd_y);
                    if (!w_cand) begin
                        r_prev_x <= w_rd_x;
                        r_prev_y <= w_rd_y;
                        r_idx    <= w_idx_nx;
                    end
                end
                ST_T_MUL: begin
                    r_prod <= w_prod;
                end
                ST_T_DLD: begin
                    r_rem  <= w_pmag[PW-1:DW];
                    r_quo  <= w_pmag[DW-1:0];
                    r_dmag <= w_dmag;
                    r_qneg <= r_prod[PW-1] ^ r_den[DW-1];
                    r_step <= '0;
                end
                ST_T_DIV: begin
                    r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_quo  <= {r_quo[DW-2:0], w_ge};
                    r_step <= r_step + SW'(1);
                end
                ST_T_SUM: begin
                    r_inside <= r_inside ^ w_hit;
                    r_prev_x <= r_cur_x;
                    r_prev_y <= r_cur_y;
                    r_idx    <= w_idx_nx;
                end
                ST_DONE: begin
                    r_prev_x <= r_prev_x;
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase

            if (w_out_load) begin
                r_o_valid  <= 1'b1;
                r_o_inside <= r_inside;
                r_o_same   <= r_same;
                r_o_count  <= r_count;
                r_o_status <= r_status;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign i_cmd.ready        = w_in_ready;
    assign o_res.valid        = r_o_valid;
    assign o_res.inside_res   = r_o_inside;
    assign o_res.same_as_last = r_o_same;
    assign o_res.vertex_count = r_o_count;
    assign o_res.status       = r_o_status;
endmodule

>>> rtl/core/pcu_checker.sv
// ----------------------------------------------------------------------------
// Polygon containment port checker
// Port-level checks on command pacing and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcu_checker #(
    parameter int MAX_VERTICES = 256,
    parameter int CNT_BITS     = 9
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_inside_res,
    input logic                i_same_as_last,
    input logic [CNT_BITS-1:0] i_vertex_count,
    input logic [1:0]          i_status
);
    import pcu_pkg::*;

    `ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "command taken while busy")
    `ASSERT_IMPL(a_full_count, i_clk, i_rst_n, i_out_valid && (i_status == STAT_FULL), i_vertex_count == CNT_BITS'(MAX_VERTICES), "full status without full store")
    `ASSERT_IMPL(a_inside_clean, i_clk, i_rst_n, i_out_valid && i_inside_res, (i_status == STAT_OK) && !i_same_as_last, "inside flag with other result bits")
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_inside_res, i_same_as_last, i_vertex_count, i_status}), "result changed while stalled")
endmodule

bind polygon_point_containment_unit pcu_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .CNT_BITS     ($clog2(MAX_VERTICES + 1))
) u_pcu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_inside_res   (o_res.inside_res),
    .i_same_as_last (o_res.same_as_last),
    .i_vertex_count (o_res.vertex_count),
    .i_status       (o_res.status)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polygon point containment unit testbench
// Feeds add, delete, clear, compare and point-test commands through the
// command channel and checks every result against an in-bench polygon model
// that keeps its own vertex list, bounding box and crossing-number walk.
// Both channels idle at random; a command marked sync waits for the result queue to
// drain before it is sent.
// ----------------------------------------------------------------------------
module tb;
    import pcu_pkg::*;

    localparam int MAX_VERTS    = 256;
    localparam int RANDOM_ITEMS = 1170;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        t_op                op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 sync;
    } cmd_item_t;

    typedef struct {
        logic       enclosed;
        logic       same;
        logic [8:0] count;
        t_status    status;
    } poly_result_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } vertex_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pcu_in_if  #(.COORD_BITS(16)) cmd_ch ();
    pcu_out_if #(.CNT_BITS(9))    res_ch ();

    polygon_point_containment_unit #(
        .MAX_VERTICES(MAX_VERTS),
        .COORD_BITS  (16)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source)
    );

    // polygon model state
    logic signed [15:0] poly_x [MAX_VERTS];
    logic signed [15:0] poly_y [MAX_VERTS];
    int                 poly_count = 0;
    logic signed [15:0] box_lo_x = '0;
    logic signed [15:0] box_hi_x = '0;
    logic signed [15:0] box_lo_y = '0;
    logic signed [15:0] box_hi_y = '0;

    cmd_item_t    cmd_queue [$];
    poly_result_t expected_results [$];
    vertex_t      shape [$];

    int   stim_count  = 0;
    int   fail_count  = 0;
    int   cycle_count = 0;
    int   cmd_gap     = 0;
    int   cmd_run     = 0;
    int   res_stall   = 0;
    int   res_run     = 0;
    logic cmd_taken   = 1'b0;
    logic res_taken   = 1'b0;
    int   wx_lo = -32768, wx_hi = 32767, wy_lo = -32768, wy_hi = 32767;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic point_enclosed(logic signed [15:0] px, logic signed [15:0] py);
        logic   parity;
        int     j;
        longint xi, yi, xj, yj, den, xcut, lpx, lpy;
        parity = 1'b0;
        if (!(box_lo_x < px && box_hi_x > px && box_lo_y < py && box_hi_y > py))
            return 1'b0;
        if (poly_count == 0)
            return 1'b0;
        lpx = px;
        lpy = py;
        j = poly_count - 1;
        for (int i = 0; i < poly_count; i++) begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if (((yi < lpy && yj >= lpy) || (yj < lpy && yi >= lpy)) &&
                (xi <= lpx || xj <= lpx)) begin
                den = yj - yi;
                if (den != 0) begin
                    xcut = xi + ((lpy - yi) * (xj - xi)) / den;
                    if (xcut < lpx)
                        parity = ~parity;
                end
            end
            j = i;
        end
        return parity;
    endfunction

    function automatic poly_result_t apply_command(logic [2:0] op, logic signed [15:0] px,
                                                   logic signed [15:0] py);
        poly_result_t r;
        r.enclosed = 1'b0;
        r.same     = 1'b0;
        r.status   = STAT_OK;
        case (op)
            OP_ADD: begin
                if (poly_count >= MAX_VERTS) begin
                    r.status = STAT_FULL;
                end else begin
                    poly_x[poly_count] = px;
                    poly_y[poly_count] = py;
                    if (poly_count == 0) begin
                        box_lo_x = px;
                        box_hi_x = px;
                        box_lo_y = py;
                        box_hi_y = py;
                    end else begin
                        if (px > box_hi_x)
                            box_hi_x = px;
                        else if (box_lo_x > px)
                            box_lo_x = px;
                        if (py > box_hi_y)
                            box_hi_y = py;
                        else if (box_lo_y > py)
                            box_lo_y = py;
                    end
                    poly_count++;
                end
            end
            OP_DELETE: begin
                if (poly_count > 0)
                    poly_count--;
            end
            OP_TEST: begin
                r.enclosed = point_enclosed(px, py);
            end
            OP_COMPARE: begin
                if (poly_count == 0)
                    r.status = STAT_EMPTY;
                else
                    r.same = (poly_x[poly_count-1] == px) && (poly_y[poly_count-1] == py);
            end
            OP_CLEAR: begin
                poly_count = 0;
            end
            default: ;
        endcase
        r.count = poly_count[8:0];
        return r;
    endfunction

    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            run = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic logic signed [15:0] any_coord();
        logic [31:0] v;
        v = $urandom;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] coord_in(int lo, int hi);
        logic [31:0] v;
        v = lo + $urandom_range(0, hi - lo);
        return v[15:0];
    endfunction

    task automatic pick_window(output int lo, output int hi);
        int c;
        int half;
        c = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 4))
            0: half = 4;
            1: half = 40;
            2: half = 2000;
            3: begin
                half = 300;
                c = $urandom_range(0, 1) ? 32767 : -32768;
            end
            default: begin
                half = 32768;
                c = 0;
            end
        endcase
        lo = (c - half < -32768) ? -32768 : c - half;
        hi = (c + half > 32767) ? 32767 : c + half;
    endtask

    task automatic push_cmd(input t_op op, input logic signed [15:0] x,
                            input logic signed [15:0] y, input bit sync = 1'b0);
        cmd_item_t item;
        vertex_t   v;
        item.op   = op;
        item.x    = x;
        item.y    = y;
        item.sync = sync;
        cmd_queue.push_back(item);
        stim_count++;
        v.x = x;
        v.y = y;
        case (op)
            OP_ADD:    if (shape.size() < MAX_VERTS) shape.push_back(v);
            OP_DELETE: if (shape.size() > 0) void'(shape.pop_back());
            OP_CLEAR:  shape.delete();
            default: ;
        endcase
    endtask

    task automatic gen_point(output logic signed [15:0] x, output logic signed [15:0] y);
        int      k;
        vertex_t v;
        k = $urandom_range(0, 19);
        x = coord_in(wx_lo, wx_hi);
        y = coord_in(wy_lo, wy_hi);
        if (k < 3 && shape.size() > 0) begin
            v = shape[$urandom_range(0, shape.size() - 1)];
            if ($urandom_range(0, 1))
                y = v.y;
            else
                x = v.x;
        end else if (k < 5) begin
            x = any_coord();
            y = any_coord();
        end
    endtask

    task automatic add_window_vertices(input int n);
        repeat (n) push_cmd(OP_ADD, coord_in(wx_lo, wx_hi), coord_in(wy_lo, wy_hi));
    endtask

    task automatic query_shape(input int m);
        int                 k;
        logic signed [15:0] px, py;
        repeat (m) begin
            k = $urandom_range(0, 9);
            gen_point(px, py);
            if (k < 6) begin
                push_cmd(OP_TEST, px, py);
            end else if (k < 8) begin
                if (shape.size() > 0 && $urandom_range(0, 1))
                    push_cmd(OP_COMPARE, shape[$].x, shape[$].y);
                else
                    push_cmd(OP_COMPARE, px, py);
            end else if (k == 8) begin
                push_cmd(OP_DELETE, any_coord(), any_coord());
            end else begin
                add_window_vertices(1);
            end
        end
    endtask

    task automatic build_directed();
        push_cmd(OP_COMPARE, 16'sd0, 16'sd0);
        push_cmd(OP_TEST, 16'sd0, 16'sd0);
        push_cmd(OP_DELETE, 16'sd0, 16'sd0);
        push_cmd(OP_CLEAR, -16'sd1, -16'sd1);
        push_cmd(OP_ADD, -16'sd32768, -16'sd32768);
        push_cmd(OP_ADD, 16'sd32767, -16'sd32768);
        push_cmd(OP_ADD, 16'sd32767, 16'sd32767);
        push_cmd(OP_ADD, -16'sd32768, 16'sd32767);
        push_cmd(OP_TEST, 16'sd0, 16'sd0);
        push_cmd(OP_TEST, -16'sd32768, 16'sd0);
        push_cmd(OP_TEST, 16'sd32767, 16'sd32767);
        push_cmd(OP_COMPARE, -16'sd32768, 16'sd32767);
        push_cmd(OP_COMPARE, -16'sd32768, -16'sd32768);
        push_cmd(OP_TEST, -16'sd1, -16'sd1);
        push_cmd(OP_DELETE, 16'sd0, 16'sd0);
        push_cmd(OP_TEST, 16'sd100, -16'sd100);
        push_cmd(OP_TEST, -16'sd100, 16'sd100);
        push_cmd(OP_CLEAR, 16'sd0, 16'sd0);
        push_cmd(OP_TEST, 16'sd0, 16'sd0);
        push_cmd(OP_COMPARE, 16'sd0, 16'sd0);
        push_cmd(OP_ADD, 16'sd5, 16'sd5);
        push_cmd(OP_ADD, -16'sd5, -16'sd5);
        push_cmd(OP_ADD, 16'sd5, -16'sd5);
        push_cmd(OP_TEST, 16'sd2, 16'sd0);
        push_cmd(OP_TEST, 16'sd4, -16'sd5);
    endtask

    task automatic build_random();
        int                 start;
        int                 r;
        bit                 filled;
        logic signed [15:0] px, py;
        start  = stim_count;
        filled = 1'b0;
        while (stim_count - start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (!filled && stim_count - start > 500) begin
                filled = 1'b1;
                push_cmd(OP_CLEAR, any_coord(), any_coord(), 1'b1);
                pick_window(wx_lo, wx_hi);
                pick_window(wy_lo, wy_hi);
                add_window_vertices(MAX_VERTS + 3);
                push_cmd(OP_COMPARE, shape[$].x, shape[$].y);
                repeat (3) begin
                    gen_point(px, py);
                    push_cmd(OP_TEST, px, py);
                end
                push_cmd(OP_DELETE, any_coord(), any_coord());
                push_cmd(OP_DELETE, any_coord(), any_coord());
                add_window_vertices(1);
                push_cmd(OP_COMPARE, shape[$].x, shape[$].y);
                push_cmd(OP_CLEAR, any_coord(), any_coord());
            end else if (r < 65) begin
                push_cmd(OP_CLEAR, any_coord(), any_coord(), $urandom_range(0, 19) == 0);
                pick_window(wx_lo, wx_hi);
                pick_window(wy_lo, wy_hi);
                add_window_vertices($urandom_range(3, 12));
                query_shape($urandom_range(4, 10));
            end else if (r < 80) begin
                repeat ($urandom_range(1, 6))
                    push_cmd(t_op'($urandom_range(0, 4)), any_coord(), any_coord());
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        repeat ($urandom_range(1, 4))
                            push_cmd(OP_DELETE, any_coord(), any_coord());
                        query_shape(2);
                    end
                    1: begin
                        push_cmd(OP_CLEAR, any_coord(), any_coord());
                        add_window_vertices($urandom_range(1, 2));
                        query_shape(3);
                    end
                    2: begin
                        push_cmd(OP_CLEAR, any_coord(), any_coord());
                        gen_point(px, py);
                        push_cmd(OP_TEST, px, py);
                        push_cmd(OP_COMPARE, px, py);
                    end
                    default: begin
                        if (shape.size() < 20)
                            add_window_vertices($urandom_range(1, 3));
                        query_shape(2);
                    end
                endcase
            end
        end
    endtask

    always @(negedge i_clk) begin
        cmd_item_t item;
        if (i_rst_n && !(cmd_ch.valid && !cmd_taken)) begin
            if (cmd_taken)
                cmd_gap = draw_wait(cmd_run);
            if (cmd_gap > 0) begin
                cmd_gap--;
                cmd_ch.valid <= 1'b0;
            end else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].sync && expected_results.size() != 0)) begin
                item = cmd_queue.pop_front();
                cmd_ch.op      <= item.op;
                cmd_ch.point_x <= item.x;
                cmd_ch.point_y <= item.y;
                cmd_ch.valid   <= 1'b1;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (res_taken)
            res_stall = draw_wait(res_run);
        if (res_stall > 0) begin
            res_stall--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        poly_result_t want;
        cycle_count <= cycle_count + 1;
        cmd_taken   <= i_rst_n && cmd_ch.valid && cmd_ch.ready;
        res_taken   <= i_rst_n && res_ch.valid && res_ch.ready;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("cycle %0d: result with none pending: inside=%0d same=%0d count=%0d status=%0d",
                             cycle_count, res_ch.inside_res, res_ch.same_as_last,
                             res_ch.vertex_count, res_ch.status);
            end else begin
                want = expected_results.pop_front();
                if (res_ch.inside_res !== want.enclosed || res_ch.same_as_last !== want.same ||
                    res_ch.vertex_count !== want.count || res_ch.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("cycle %0d: mismatch exp inside=%0d same=%0d count=%0d status=%0d, got inside=%0d same=%0d count=%0d status=%0d",
                                 cycle_count, want.enclosed, want.same, want.count,
                                 want.status, res_ch.inside_res, res_ch.same_as_last,
                                 res_ch.vertex_count, res_ch.status);
                end
            end
        end
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            expected_results.push_back(apply_command(cmd_ch.op, cmd_ch.point_x,
                                                     cmd_ch.point_y));
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.op      = OP_ADD;
        cmd_ch.point_x = '0;
        cmd_ch.point_y = '0;
        res_ch.ready   = 1'b0;
        build_directed();
        build_random();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_queue.size() != 0 || cmd_ch.valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pcu_pkg.sv
rtl/core/pcu_in_if.sv
rtl/core/pcu_out_if.sv
rtl/core/pcu_ram.sv
rtl/core/polygon_point_containment_unit.sv
rtl/core/pcu_checker.sv
tb/sv/tb.sv
